[sv/nbl_pkg.sv]
// Shared types, widths and codes for the leapfrog N-body stepper.
package nbl_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 10;
    localparam int POS_W    = 48;
    localparam int MASS_W   = 47;
    localparam int STEPS_W  = 21;
    localparam int DT_W     = 47;
    localparam int PCNT_W   = 11;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 4;

    localparam int Q_W      = 98;
    localparam int R_W      = 49;
    localparam int D_W      = 74;
    localparam int WIDE_W   = 128;
    localparam int MUL_A_W  = 80;
    localparam int MUL_B_W  = 49;
    localparam int QUO_W    = 48;

    localparam logic [OPCODE_W-1:0] OPC_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_RUN  = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_READ = 2'd2;

    localparam logic RK_READ = 1'b0;
    localparam logic RK_STEP = 1'b1;

    localparam logic [DT_W-1:0]   DT_RESET = 47'd8388608;
    localparam logic [PCNT_W-1:0] PCNT_RESET = '0;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [INDEX_W-1:0]      index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic [MASS_W-1:0]       mass;
        logic [STEPS_W-1:0]      step_count;
    } cmd_t;

    typedef struct packed {
        logic                    result_kind;
        logic [INDEX_W-1:0]      out_index;
        logic signed [POS_W-1:0] out_pos_x;
        logic signed [POS_W-1:0] out_pos_y;
        logic signed [POS_W-1:0] out_vel_x;
        logic signed [POS_W-1:0] out_vel_y;
        logic [MASS_W-1:0]       out_mass;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_SLOT,
        OP_CAPTURE,
        OP_STEP_RSP,
        OP_READ,
        OP_LATCH_I,
        OP_DIFF,
        OP_MUL_SQ,
        OP_TAKE_Q,
        OP_SQRT,
        OP_TAKE_R,
        OP_MUL_DEN,
        OP_TAKE_DEN,
        OP_MUL_NY,
        OP_TAKE_NY,
        OP_DIV,
        OP_TAKE_DIV,
        OP_MUL_KICK,
        OP_TAKE_KICK,
        OP_MUL_DRIFT,
        OP_TAKE_DRIFT,
        OP_WRITE_VEL,
        OP_COPY
    } dp_op_t;

    typedef struct packed {
        logic mul_busy;
        logic sqrt_busy;
        logic div_busy;
        logic q_zero;
    } dp_status_t;

endpackage

[sv/nbody_leapfrog_step.sv]
// Top level: configuration registers, controller and datapath of the N-body stepper.
//
// A load leaves busy low. A read captures its item in the response register while in
// S_READ and then shows it on rsp with done high. A run command holds busy high
// through every leapfrog step, then gives one completion item; each interacting pair
// is handled in turn by the bit-serial multipliers, square root and dividers.
// Results are shown for one cycle on done and cannot be held off.
module nbody_leapfrog_step
    import nbl_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);

    logic [DT_W-1:0]   timestep_reg;
    logic [PCNT_W-1:0] count_reg;
    dp_op_t            op;
    dp_status_t        status;
    logic [IDX_W-1:0]  addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timestep_reg <= DT_RESET;
            count_reg    <= PCNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3])
            begin
                count_reg <= pwdata[PCNT_W-1:0];
            end
            else
            begin
                timestep_reg <= pwdata[DT_W-1:0];
            end
        end
    end

    assign prdata = paddr[3] ? CFG_W'(count_reg) : CFG_W'(timestep_reg);
    assign pready = 1'b1;

    nbl_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .clk, .rst_n, .start, .cmd, .particle_count(count_reg), .status,
        .busy, .done, .op, .addr);

    nbl_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .clk, .rst_n, .cmd, .op, .addr, .dt(timestep_reg), .status, .rsp);

endmodule

[sv/nbl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module nbl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/nbl_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
module nbl_mul
    import nbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               busy,
    output logic [WIDE_W-1:0]  p
);

    localparam int CW = $clog2(MUL_B_W + 1);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] ash_reg;
    logic [MUL_B_W-1:0] bsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(MUL_B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= WIDE_W'(a);
            bsh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= {ash_reg[WIDE_W-2:0], 1'b0};
            bsh_reg <= {1'b0, bsh_reg[MUL_B_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign p    = acc_reg;

endmodule

[sv/nbl_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module nbl_sqrt
    import nbl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [Q_W-1:0] v,
    output logic           busy,
    output logic [R_W-1:0] root
);

    localparam int CW  = $clog2(R_W + 1);
    localparam int RM_W = R_W + 3;

    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic [RM_W-1:0] rem_reg;
    logic [R_W-1:0]  root_reg;
    logic [Q_W-1:0]  vsh_reg;
    logic [RM_W-1:0] t;
    logic [RM_W-1:0] trial;

    assign t     = {rem_reg[RM_W-3:0], vsh_reg[Q_W-1:Q_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(R_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            vsh_reg  <= v;
        end
        else if (busy_reg)
        begin
            if (t >= trial)
            begin
                rem_reg  <= t - trial;
                root_reg <= {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= t;
                root_reg <= {root_reg[R_W-2:0], 1'b0};
            end
            vsh_reg <= {vsh_reg[Q_W-3:0], 2'b00};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[sv/nbl_div.sv]
// Restoring divider, one quotient bit per cycle, flags results past 47 bits.
module nbl_div
    import nbl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] num,
    input  logic [WIDE_W-1:0] den,
    output logic              busy,
    output logic              ovf,
    output logic [QUO_W-2:0]  mag
);

    localparam int CW = $clog2(QUO_W + 1);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [WIDE_W:0]   rem_reg;
    logic [QUO_W-1:0]  nsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [WIDE_W-1:0] den_reg;
    logic              big_reg;
    logic [WIDE_W:0]   t;

    assign t = {rem_reg[WIDE_W-1:0], nsh_reg[QUO_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            big_reg <= (WIDE_W'(num[WIDE_W-1:QUO_W]) >= den);
            rem_reg <= (WIDE_W+1)'(num[WIDE_W-1:QUO_W]);
            nsh_reg <= num[QUO_W-1:0];
            quo_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (t >= {1'b0, den_reg})
            begin
                rem_reg <= t - {1'b0, den_reg};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= t;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            nsh_reg <= {nsh_reg[QUO_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign ovf  = big_reg | quo_reg[QUO_W-1];
    assign mag  = quo_reg[QUO_W-2:0];

endmodule

[sv/nbl_dp.sv]
// Datapath: particle memories, arithmetic units and working registers.
module nbl_dp
    import nbl_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmd_t                             cmd,
    input  dp_op_t                           op,
    input  logic [$clog2(MAX_PARTICLES)-1:0] addr,
    input  logic [DT_W-1:0]                  dt,
    output dp_status_t                       status,
    output rsp_t                             rsp
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam logic [INDEX_W:0] MAX_R = (INDEX_W + 1)'(MAX_PARTICLES);
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [D_W-1:0] D_ONE = D_W'(1) << 24;

    function automatic logic [IDX_W-1:0] slot_of(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W:0] r;
        int b;
        r = '0;
        for (b = INDEX_W - 1; b >= 0; b--)
        begin
            r = {r[INDEX_W-1:0], idx[b]};
            if (32'(r) >= 32'(MAX_PARTICLES))
            begin
                r = r - MAX_R;
            end
        end
        return IDX_W'(r);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                        input logic signed [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        if (s[POS_W] != s[POS_W-1])
        begin
            return s[POS_W] ? POS_MIN : POS_MAX;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                        input logic [POS_W-2:0] m);
        if (ovf)
        begin
            return neg ? POS_MIN : POS_MAX;
        end
        return neg ? -{1'b0, m} : {1'b0, m};
    endfunction

    function automatic logic signed [POS_W-1:0] scale(input logic [WIDE_W-1:0] p,
                                                      input logic neg, input logic half);
        if (half)
        begin
            return sat_mag(neg, |p[WIDE_W-1:72], p[71:25]);
        end
        return sat_mag(neg, |p[WIDE_W-1:71], p[70:24]);
    endfunction

    function automatic logic [POS_W-1:0] abs48(input logic signed [POS_W-1:0] v);
        return v[POS_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;

    logic [POS_W-1:0]  px_rd, py_rd, vx_rd, vy_rd, nx_rd, ny_rd;
    logic [MASS_W-1:0] m_rd;
    logic              pos_we, vel_we, mass_we, nxt_we;
    logic [POS_W-1:0]  px_wd, py_wd, vx_wd, vy_wd, nxx_wd, nxy_wd;
    logic [MASS_W-1:0] m_wd;

    logic signed [POS_W-1:0] pix_reg, piy_reg, vx_reg, vy_reg, sx_reg, sy_reg;
    logic [POS_W-1:0]        mx_reg, my_reg;
    logic                    nx_reg, ny_reg;
    logic [MASS_W-1:0]       mj_reg;
    logic [Q_W-1:0]          q_reg;
    logic [R_W-1:0]          rr_reg;
    logic [D_W-1:0]          dd_reg;
    logic [WIDE_W-1:0]       den_reg, numx_reg, numy_reg;
    rsp_t                    rsp_reg;

    logic               mula_start, mulb_start, mula_busy, mulb_busy;
    logic [MUL_A_W-1:0] mula_a, mulb_a;
    logic [MUL_B_W-1:0] mula_b, mulb_b;
    logic [WIDE_W-1:0]  pa, pb;
    logic               sq_start, sq_busy;
    logic [R_W-1:0]     root;
    logic               div_start, divx_busy, divy_busy, ovfx, ovfy;
    logic [POS_W-2:0]   qx, qy;
    logic [POS_W:0]     dxw, dyw, dxa, dya;

    assign slot  = slot_of(cmd.index);
    assign raddr = (op == OP_READ_SLOT) ? slot : addr;
    assign waddr = (op == OP_LOAD) ? slot : addr;

    assign pos_we  = (op == OP_LOAD) || (op == OP_COPY);
    assign vel_we  = (op == OP_LOAD) || (op == OP_TAKE_DRIFT) || (op == OP_WRITE_VEL);
    assign mass_we = (op == OP_LOAD);
    assign nxt_we  = (op == OP_TAKE_DRIFT);

    assign px_wd  = (op == OP_LOAD) ? cmd.pos_x : nx_rd;
    assign py_wd  = (op == OP_LOAD) ? cmd.pos_y : ny_rd;
    assign vx_wd  = (op == OP_LOAD) ? cmd.vel_x : vx_reg;
    assign vy_wd  = (op == OP_LOAD) ? cmd.vel_y : vy_reg;
    assign m_wd   = cmd.mass;
    assign nxx_wd = sat_add(pix_reg, scale(pa, vx_reg[POS_W-1], 1'b0));
    assign nxy_wd = sat_add(piy_reg, scale(pb, vy_reg[POS_W-1], 1'b0));

    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_pos_x (
        .clk, .we(pos_we), .waddr, .wdata(px_wd), .raddr, .rdata(px_rd));
    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_pos_y (
        .clk, .we(pos_we), .waddr, .wdata(py_wd), .raddr, .rdata(py_rd));
    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_vel_x (
        .clk, .we(vel_we), .waddr, .wdata(vx_wd), .raddr, .rdata(vx_rd));
    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_vel_y (
        .clk, .we(vel_we), .waddr, .wdata(vy_wd), .raddr, .rdata(vy_rd));
    nbl_ram #(.WIDTH(MASS_W), .DEPTH(MAX_PARTICLES)) u_mass (
        .clk, .we(mass_we), .waddr, .wdata(m_wd), .raddr, .rdata(m_rd));
    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_next_x (
        .clk, .we(nxt_we), .waddr, .wdata(nxx_wd), .raddr, .rdata(nx_rd));
    nbl_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_next_y (
        .clk, .we(nxt_we), .waddr, .wdata(nxy_wd), .raddr, .rdata(ny_rd));

    always_comb
    begin
        mula_start = 1'b0;
        mulb_start = 1'b0;
        mula_a     = '0;
        mula_b     = '0;
        mulb_a     = '0;
        mulb_b     = '0;
        case (op)
            OP_MUL_SQ:
            begin
                mula_start = 1'b1;
                mulb_start = 1'b1;
                mula_a     = MUL_A_W'(mx_reg);
                mula_b     = MUL_B_W'(mx_reg);
                mulb_a     = MUL_A_W'(my_reg);
                mulb_b     = MUL_B_W'(my_reg);
            end
            OP_MUL_DEN:
            begin
                mula_start = 1'b1;
                mulb_start = 1'b1;
                mula_a     = MUL_A_W'(dd_reg);
                mula_b     = rr_reg;
                mulb_a     = MUL_A_W'(mj_reg);
                mulb_b     = MUL_B_W'(mx_reg);
            end
            OP_MUL_NY:
            begin
                mulb_start = 1'b1;
                mulb_a     = MUL_A_W'(mj_reg);
                mulb_b     = MUL_B_W'(my_reg);
            end
            OP_MUL_KICK:
            begin
                mula_start = 1'b1;
                mulb_start = 1'b1;
                mula_a     = MUL_A_W'(abs48(sx_reg));
                mula_b     = MUL_B_W'(dt);
                mulb_a     = MUL_A_W'(abs48(sy_reg));
                mulb_b     = MUL_B_W'(dt);
            end
            OP_MUL_DRIFT:
            begin
                mula_start = 1'b1;
                mulb_start = 1'b1;
                mula_a     = MUL_A_W'(abs48(vx_reg));
                mula_b     = MUL_B_W'(dt);
                mulb_a     = MUL_A_W'(abs48(vy_reg));
                mulb_b     = MUL_B_W'(dt);
            end
            default:
            begin
                mula_start = 1'b0;
            end
        endcase
    end

    assign sq_start  = (op == OP_SQRT);
    assign div_start = (op == OP_DIV);

    nbl_mul u_mul_a (.clk, .rst_n, .start(mula_start), .a(mula_a), .b(mula_b),
                     .busy(mula_busy), .p(pa));
    nbl_mul u_mul_b (.clk, .rst_n, .start(mulb_start), .a(mulb_a), .b(mulb_b),
                     .busy(mulb_busy), .p(pb));
    nbl_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .v(q_reg), .busy(sq_busy), .root);
    nbl_div u_div_x (.clk, .rst_n, .start(div_start), .num(numx_reg), .den(den_reg),
                     .busy(divx_busy), .ovf(ovfx), .mag(qx));
    nbl_div u_div_y (.clk, .rst_n, .start(div_start), .num(numy_reg), .den(den_reg),
                     .busy(divy_busy), .ovf(ovfy), .mag(qy));

    assign dxw = {px_rd[POS_W-1], px_rd} - {pix_reg[POS_W-1], pix_reg};
    assign dyw = {py_rd[POS_W-1], py_rd} - {piy_reg[POS_W-1], piy_reg};
    assign dxa = dxw[POS_W] ? -dxw : dxw;
    assign dya = dyw[POS_W] ? -dyw : dyw;

    always_ff @(posedge clk)
    begin
        case (op)
            OP_READ_SLOT:
            begin
                slot_reg <= slot;
            end
            OP_CAPTURE:
            begin
                rsp_reg.result_kind <= RK_READ;
                rsp_reg.out_index   <= INDEX_W'(32'(slot_reg));
                rsp_reg.out_pos_x   <= px_rd;
                rsp_reg.out_pos_y   <= py_rd;
                rsp_reg.out_vel_x   <= vx_rd;
                rsp_reg.out_vel_y   <= vy_rd;
                rsp_reg.out_mass    <= m_rd;
            end
            OP_STEP_RSP:
            begin
                rsp_reg.result_kind <= RK_STEP;
                rsp_reg.out_index   <= '0;
                rsp_reg.out_pos_x   <= '0;
                rsp_reg.out_pos_y   <= '0;
                rsp_reg.out_vel_x   <= '0;
                rsp_reg.out_vel_y   <= '0;
                rsp_reg.out_mass    <= '0;
            end
            OP_LATCH_I:
            begin
                pix_reg <= px_rd;
                piy_reg <= py_rd;
                vx_reg  <= vx_rd;
                vy_reg  <= vy_rd;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            OP_DIFF:
            begin
                mx_reg <= dxa[POS_W-1:0];
                my_reg <= dya[POS_W-1:0];
                nx_reg <= dxw[POS_W];
                ny_reg <= dyw[POS_W];
                mj_reg <= m_rd;
            end
            OP_TAKE_Q:
            begin
                q_reg <= pa[Q_W-1:0] + pb[Q_W-1:0];
            end
            OP_SQRT:
            begin
                dd_reg <= q_reg[Q_W-1:24] + D_ONE;
            end
            OP_TAKE_R:
            begin
                rr_reg <= root;
            end
            OP_TAKE_DEN:
            begin
                den_reg  <= pa + {pa[WIDE_W-3:0], 2'b00};
                numx_reg <= {pb[WIDE_W-25:0], 24'd0};
            end
            OP_TAKE_NY:
            begin
                numy_reg <= {pb[WIDE_W-25:0], 24'd0};
            end
            OP_TAKE_DIV:
            begin
                sx_reg <= sat_add(sx_reg, sat_mag(nx_reg, ovfx, qx));
                sy_reg <= sat_add(sy_reg, sat_mag(ny_reg, ovfy, qy));
            end
            OP_TAKE_KICK:
            begin
                vx_reg <= sat_add(vx_reg, scale(pa, sx_reg[POS_W-1], 1'b1));
                vy_reg <= sat_add(vy_reg, scale(pb, sy_reg[POS_W-1], 1'b1));
            end
            default:
            begin
                slot_reg <= slot_reg;
            end
        endcase
    end

    assign status.mul_busy  = mula_busy | mulb_busy;
    assign status.sqrt_busy = sq_busy;
    assign status.div_busy  = divx_busy | divy_busy;
    assign status.q_zero    = (q_reg == '0);
    assign rsp              = rsp_reg;

endmodule

[sv/nbl_ctrl.sv]
// Controller: command decode and sequencing of the leapfrog passes.
module nbl_ctrl
    import nbl_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  cmd_t                             cmd,
    input  logic [PCNT_W-1:0]                particle_count,
    input  dp_status_t                       status,
    output logic                             busy,
    output logic                             done,
    output dp_op_t                           op,
    output logic [$clog2(MAX_PARTICLES)-1:0] addr
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_FIN, S_SCHK, S_ICHK, S_RDI, S_LATI, S_JCHK, S_RDJ, S_DIFF,
        S_SQ, S_SQ_W, S_QCHK, S_RT_W, S_M2, S_M2_W, S_M3, S_M3_W, S_DV, S_DV_W,
        S_KICK, S_KICK_W, S_DRIFT, S_DRIFT_W, S_WVEL, S_CCHK, S_CRD, S_CWR
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic               pass_reg, pass_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   n_clip;

    assign n_clip = (32'(particle_count) > 32'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                             : CNT_W'(particle_count);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        steps_next = steps_reg;
        pass_next  = pass_reg;
        done_next  = 1'b0;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.opcode)
                        OPC_LOAD: op = OP_LOAD;
                        OPC_READ:
                        begin
                            op         = OP_READ_SLOT;
                            state_next = S_READ;
                        end
                        OPC_RUN:
                        begin
                            n_next     = n_clip;
                            steps_next = cmd.step_count;
                            state_next = S_SCHK;
                        end
                        default: op = OP_NONE;
                    endcase
                end
            end
            S_READ:
            begin
                op         = OP_CAPTURE;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                op         = OP_STEP_RSP;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCHK:
            begin
                i_next     = '0;
                pass_next  = 1'b0;
                state_next = (steps_reg == '0) ? S_FIN : S_ICHK;
            end
            S_ICHK:
            begin
                if (i_reg == n_reg)
                begin
                    i_next = '0;
                    if (!pass_reg)
                    begin
                        state_next = S_CCHK;
                    end
                    else
                    begin
                        steps_next = steps_reg - 1'b1;
                        state_next = S_SCHK;
                    end
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_RDI;
                end
            end
            S_RDI:
            begin
                op         = OP_READ;
                state_next = S_LATI;
            end
            S_LATI:
            begin
                op         = OP_LATCH_I;
                state_next = S_JCHK;
            end
            S_JCHK:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = S_KICK;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_RDJ;
                end
            end
            S_RDJ:
            begin
                op         = OP_READ;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                op         = OP_DIFF;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                op         = OP_MUL_SQ;
                state_next = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (!status.mul_busy)
                begin
                    op         = OP_TAKE_Q;
                    state_next = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (status.q_zero)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_JCHK;
                end
                else
                begin
                    op         = OP_SQRT;
                    state_next = S_RT_W;
                end
            end
            S_RT_W:
            begin
                if (!status.sqrt_busy)
                begin
                    op         = OP_TAKE_R;
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                op         = OP_MUL_DEN;
                state_next = S_M2_W;
            end
            S_M2_W:
            begin
                if (!status.mul_busy)
                begin
                    op         = OP_TAKE_DEN;
                    state_next = S_M3;
                end
            end
            S_M3:
            begin
                op         = OP_MUL_NY;
                state_next = S_M3_W;
            end
            S_M3_W:
            begin
                if (!status.mul_busy)
                begin
                    op         = OP_TAKE_NY;
                    state_next = S_DV;
                end
            end
            S_DV:
            begin
                op         = OP_DIV;
                state_next = S_DV_W;
            end
            S_DV_W:
            begin
                if (!status.div_busy)
                begin
                    op         = OP_TAKE_DIV;
                    j_next     = j_reg + 1'b1;
                    state_next = S_JCHK;
                end
            end
            S_KICK:
            begin
                op         = OP_MUL_KICK;
                state_next = S_KICK_W;
            end
            S_KICK_W:
            begin
                if (!status.mul_busy)
                begin
                    op         = OP_TAKE_KICK;
                    state_next = pass_reg ? S_WVEL : S_DRIFT;
                end
            end
            S_DRIFT:
            begin
                op         = OP_MUL_DRIFT;
                state_next = S_DRIFT_W;
            end
            S_DRIFT_W:
            begin
                if (!status.mul_busy)
                begin
                    op         = OP_TAKE_DRIFT;
                    i_next     = i_reg + 1'b1;
                    state_next = S_ICHK;
                end
            end
            S_WVEL:
            begin
                op         = OP_WRITE_VEL;
                i_next     = i_reg + 1'b1;
                state_next = S_ICHK;
            end
            S_CCHK:
            begin
                if (i_reg == n_reg)
                begin
                    i_next     = '0;
                    pass_next  = 1'b1;
                    state_next = S_ICHK;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                op         = OP_READ;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                op         = OP_COPY;
                i_next     = i_reg + 1'b1;
                state_next = S_CCHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            steps_reg <= '0;
            pass_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            steps_reg <= steps_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign addr = (state_reg == S_RDJ) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

endmodule

[bench/tb.sv]
// Testbench for nbody_leapfrog_step: directed and random commands checked against a predictor.
module tb;
    import nbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] ADDR_TIMESTEP = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_PCOUNT   = 4'd8;
    localparam logic [OPCODE_W-1:0] OPC_UNUSED  = 2'd3;
    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_MIN = -SAT_MAX - 1;
    localparam logic [127:0] MAG_MAX = 128'h7FFF_FFFF_FFFF;
    localparam longint ONE_Q = 64'sd16777216;
    localparam int WATCHDOG_LIMIT = 50_000_000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             done;
    rsp_t             rsp;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0] pwdata = '0;
    logic [CFG_W-1:0] prdata;
    logic             pready;

    nbody_leapfrog_step u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor state
    longint          sim_px [MAX_PARTICLES_DEF];
    longint          sim_py [MAX_PARTICLES_DEF];
    longint          sim_vx [MAX_PARTICLES_DEF];
    longint          sim_vy [MAX_PARTICLES_DEF];
    longint          sim_m  [MAX_PARTICLES_DEF];
    longint          nxt_px [MAX_PARTICLES_DEF];
    longint          nxt_py [MAX_PARTICLES_DEF];
    bit              loaded [MAX_PARTICLES_DEF];
    logic [DT_W-1:0] dt_cfg = DT_RESET;
    int unsigned     pcount_cfg = 0;

    rsp_t expected_rsps[$];
    int   errors = 0;
    int   idle_cycles = 0;

    function automatic longint from_mag(bit neg, logic [127:0] m);
        if (m > MAG_MAX)
            return neg ? SAT_MIN : SAT_MAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SAT_MAX) return SAT_MAX;
        if (s < SAT_MIN) return SAT_MIN;
        return s;
    endfunction

    function automatic longint scale_by_dt(longint a, int shift);
        logic [127:0] prod;
        bit neg;
        neg = a < 0;
        prod = 128'(neg ? -a : a) * 128'(dt_cfg);
        return from_mag(neg, prod >> shift);
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] q);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 48; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (q >= t * t)
                r = t;
        end
        return r;
    endfunction

    task automatic gravity_pull(input int i, input int n, output longint ax, output longint ay);
        longint dx, dy;
        logic [127:0] mx, my, q, r, d, den;
        ax = 0;
        ay = 0;
        for (int j = 0; j < n; j++)
        begin
            if (j == i)
                continue;
            dx = sim_px[j] - sim_px[i];
            dy = sim_py[j] - sim_py[i];
            mx = 128'(dx < 0 ? -dx : dx);
            my = 128'(dy < 0 ? -dy : dy);
            q = mx * mx + my * my;
            if (q == 0)
                continue;
            r = isqrt(q);
            d = (q >> 24) + 128'(ONE_Q);
            den = r * d * 128'd5;
            ax = sat_add(ax, from_mag(dx < 0, ((128'(sim_m[j]) * mx) << 24) / den));
            ay = sat_add(ay, from_mag(dy < 0, ((128'(sim_m[j]) * my) << 24) / den));
        end
    endtask

    task automatic leapfrog(input int n);
        longint ax, ay;
        for (int i = 0; i < n; i++)
        begin
            gravity_pull(i, n, ax, ay);
            sim_vx[i] = sat_add(sim_vx[i], scale_by_dt(ax, 25));
            sim_vy[i] = sat_add(sim_vy[i], scale_by_dt(ay, 25));
            nxt_px[i] = sat_add(sim_px[i], scale_by_dt(sim_vx[i], 24));
            nxt_py[i] = sat_add(sim_py[i], scale_by_dt(sim_vy[i], 24));
        end
        for (int i = 0; i < n; i++)
        begin
            sim_px[i] = nxt_px[i];
            sim_py[i] = nxt_py[i];
        end
        for (int i = 0; i < n; i++)
        begin
            gravity_pull(i, n, ax, ay);
            sim_vx[i] = sat_add(sim_vx[i], scale_by_dt(ax, 25));
            sim_vy[i] = sat_add(sim_vy[i], scale_by_dt(ay, 25));
        end
    endtask

    task automatic predict_cmd(input cmd_t c);
        rsp_t e;
        int slot;
        int n;
        slot = int'(c.index);
        e = '0;
        case (c.opcode)
            OPC_LOAD:
            begin
                sim_px[slot] = longint'(c.pos_x);
                sim_py[slot] = longint'(c.pos_y);
                sim_vx[slot] = longint'(c.vel_x);
                sim_vy[slot] = longint'(c.vel_y);
                sim_m[slot] = longint'({17'd0, c.mass});
                loaded[slot] = 1'b1;
            end
            OPC_RUN:
            begin
                n = pcount_cfg > MAX_PARTICLES_DEF ? MAX_PARTICLES_DEF : pcount_cfg;
                if (n > 0)
                    for (int s = 0; s < int'(c.step_count); s++)
                        leapfrog(n);
                e.result_kind = RK_STEP;
                expected_rsps = {expected_rsps, e};
            end
            OPC_READ:
            begin
                e.result_kind = RK_READ;
                e.out_index = c.index;
                e.out_pos_x = sim_px[slot][POS_W-1:0];
                e.out_pos_y = sim_py[slot][POS_W-1:0];
                e.out_vel_x = sim_vx[slot][POS_W-1:0];
                e.out_vel_y = sim_vy[slot][POS_W-1:0];
                e.out_mass = sim_m[slot][MASS_W-1:0];
                expected_rsps = {expected_rsps, e};
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $realtime, rsp);
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                check_field("result_kind", 64'(e.result_kind), 64'(rsp.result_kind));
                check_field("out_index", 64'(e.out_index), 64'(rsp.out_index));
                check_field("out_pos_x", 64'(e.out_pos_x), 64'(rsp.out_pos_x));
                check_field("out_pos_y", 64'(e.out_pos_y), 64'(rsp.out_pos_y));
                check_field("out_vel_x", 64'(e.out_vel_x), 64'(rsp.out_vel_x));
                check_field("out_vel_y", 64'(e.out_vel_y), 64'(rsp.out_vel_y));
                check_field("out_mass", 64'(e.out_mass), 64'(rsp.out_mass));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] near48();
        return 48'($signed(longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000));
    endfunction

    function automatic cmd_t make_cmd(logic [OPCODE_W-1:0] op, int idx);
        cmd_t c;
        c.opcode = op;
        c.index = INDEX_W'(idx);
        c.pos_x = rand48();
        c.pos_y = rand48();
        c.vel_x = rand48();
        c.vel_y = rand48();
        c.mass = MASS_W'(rand48());
        c.step_count = STEPS_W'($urandom());
        return c;
    endfunction

    function automatic cmd_t make_load(int idx, logic [47:0] px, logic [47:0] py,
                                       logic [47:0] vx, logic [47:0] vy, logic [46:0] m);
        cmd_t c;
        c = make_cmd(OPC_LOAD, idx);
        c.pos_x = px;
        c.pos_y = py;
        c.vel_x = vx;
        c.vel_y = vy;
        c.mass = m;
        return c;
    endfunction

    function automatic cmd_t make_run(int steps);
        cmd_t c;
        c = make_cmd(OPC_RUN, $urandom_range(0, 1023));
        c.step_count = STEPS_W'(steps);
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        int g;
        cmd <= c;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        predict_cmd(c);
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TIMESTEP)
            dt_cfg = data[DT_W-1:0];
        else
            pcount_cfg = int'(data[PCNT_W-1:0]);
    endtask

    task automatic read_slot(input int idx);
        send_cmd(make_cmd(OPC_READ, idx));
    endtask

    task automatic load_moderate(input int idx);
        send_cmd(make_load(idx, near48(), near48(), near48() >>> 4, near48() >>> 4,
                           47'($urandom_range(0, 32'h0800_0000))));
    endtask

    task automatic test_field_extremes();
        send_cmd(make_load(1023, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                           48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF));
        send_cmd(make_load(0, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 47'h0));
        send_cmd(make_load(682, rand48(), rand48(), rand48(), rand48(), 47'(rand48())));
        send_cmd(make_load(341, rand48(), rand48(), rand48(), rand48(), 47'(rand48())));
        read_slot(1023);
        read_slot(0);
        read_slot(682);
        read_slot(341);
        send_cmd(make_cmd(OPC_UNUSED, 5));
        read_slot(1023);
    endtask

    task automatic test_two_body();
        drain();
        cfg_write(ADDR_PCOUNT, 64'd3);
        // two coincident bodies and one offset only in y
        send_cmd(make_load(0, 48'h100_0000, 48'h0, 48'h0, 48'h0, 47'h200_0000));
        send_cmd(make_load(1, 48'h100_0000, 48'h0, 48'h0, 48'h0, 47'h300_0000));
        send_cmd(make_load(2, 48'h100_0000, 48'h300_0000, 48'h8_0000, 48'h0, 47'h100_0000));
        send_cmd(make_run(1));
        read_slot(0);
        read_slot(1);
        read_slot(2);
        send_cmd(make_run(0));
        send_cmd(make_run(2));
        read_slot(2);
    endtask

    task automatic test_count_extremes();
        drain();
        cfg_write(ADDR_PCOUNT, 64'd1024);
        send_cmd(make_run(0));
        drain();
        cfg_write(ADDR_PCOUNT, 64'd1);
        send_cmd(make_run(3));
        read_slot(0);
        drain();
        cfg_write(ADDR_PCOUNT, 64'd0);
        send_cmd(make_run(1048575));
        send_cmd(make_run(1048576));
        read_slot(0);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] dt_list [6];
        int n_list [6];
        int n;
        int r;
        int idx;
        dt_list = '{64'h100_0000, 64'h7FFF_FFFF_FFFF, 64'h0, 64'h40_0000,
                    64'h80_0000, 64'(rand48() & 48'h3FF_FFFF)};
        n_list = '{2, 3, 4, 2, 3, 4};
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            n = n_list[ph];
            cfg_write(ADDR_TIMESTEP, dt_list[ph]);
            cfg_write(ADDR_PCOUNT, 64'(n));
            for (int i = 0; i < n; i++)
                load_moderate(i);
            for (int k = 0; k < 11; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    load_moderate($urandom_range(0, n - 1));
                else if (r < 32)
                    send_cmd(make_load($urandom_range(0, 1023), rand48(), rand48(),
                                       rand48(), rand48(), 47'(rand48())));
                else if (r < 65)
                begin
                    do idx = $urandom_range(0, 1023); while (!loaded[idx] && idx >= n);
                    if (!loaded[idx])
                        idx = $urandom_range(0, n - 1);
                    read_slot(idx);
                end
                else if (r < 95)
                    send_cmd(make_run($urandom_range(0, 2)));
                else
                    send_cmd(make_cmd(OPC_UNUSED, $urandom_range(0, 1023)));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_PARTICLES_DEF; i++)
        begin
            sim_px[i] = 0; sim_py[i] = 0; sim_vx[i] = 0; sim_vy[i] = 0;
            sim_m[i] = 0; nxt_px[i] = 0; nxt_py[i] = 0; loaded[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_two_body();
        test_count_extremes();
        test_random_phases();
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
